// File: rtl/insertion_sort_with_counters_core_assert.svh
// Assertion macros used by the checker of the insertion sorter.
`ifndef INSERTION_SORT_WITH_COUNTERS_CORE_ASSERT_SVH
`define INSERTION_SORT_WITH_COUNTERS_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ISWC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iswc assertion failed");

// Next-cycle implication, disabled during reset.
`define ISWC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iswc assertion failed");

`endif

// File: rtl/iswc_pkg.sv
// Package: widths, constants and controller/datapath types of the insertion sorter.
package iswc_pkg;

   localparam int CAPACITY = 64;
   localparam int DEPTH    = 64;
   localparam int ADDR_W   = 6;
   localparam int CNT_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int SHIFT_W  = 11;
   localparam int WRITE_W  = 12;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [ADDR_W-1:0]         addr_type;
   typedef logic [CNT_W-1:0]          count_type;
   typedef logic [SHIFT_W-1:0]        shift_type;
   typedef logic [WRITE_W-1:0]        write_type;

   // Read address source of the store
   typedef enum logic [2:0] {
      RD_I,
      RD_I_PREV,
      RD_SLOT_PREV2,
      RD_K,
      RD_K_NEXT
   } rd_sel_type;

   typedef struct packed {
      logic       store_item;
      logic       start_sort;
      rd_sel_type rd_sel;
      logic       take_key;
      logic       shift_up;
      logic       place_key;
      logic       load_out;
      logic       next_out;
      logic       clear_run;
   } cmd_type;

   typedef struct packed {
      logic sort_done;
      logic greater;
      logic slot_is_one;
      logic out_is_last;
   } status_type;

endpackage

// File: rtl/iswc_if.sv
// Interfaces: request and response channels of the insertion sorter.
interface iswc_req_if;
   logic                     valid;
   logic                     ready;
   iswc_pkg::value_type      value;
   logic                     last_in;

   modport source (output valid, output value, output last_in, input ready);
   modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface iswc_rsp_if;
   logic                     valid;
   logic                     ready;
   iswc_pkg::value_type      sorted_value;
   logic                     last_out;
   iswc_pkg::shift_type      shift_count;
   iswc_pkg::write_type      write_count;
   logic                     overflow;

   modport source (output valid, output sorted_value, output last_out,
                   output shift_count, output write_count, output overflow,
                   input ready);
   modport sink   (input valid, input sorted_value, input last_out,
                   input shift_count, input write_count, input overflow,
                   output ready);
endinterface

// File: rtl/iswc_datapath.sv
// Datapath: element store, sort indices, move counters and response register.
module iswc_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  iswc_pkg::cmd_type    cmd,
   input  iswc_pkg::value_type  item_value,
   output iswc_pkg::status_type status,
   output iswc_pkg::value_type  sorted_value,
   output logic                 last_out,
   output iswc_pkg::shift_type  shift_count,
   output iswc_pkg::write_type  write_count,
   output logic                 overflow
);

   iswc_pkg::value_type store_ff [iswc_pkg::DEPTH];
   iswc_pkg::value_type rdata_ff;
   iswc_pkg::value_type key_ff;
   iswc_pkg::value_type sorted_value_ff;
   logic                last_out_ff;

   iswc_pkg::count_type count_ff, count_in;
   iswc_pkg::count_type i_ff, i_in;
   iswc_pkg::addr_type  slot_ff, slot_in;
   iswc_pkg::addr_type  k_ff, k_in;
   iswc_pkg::shift_type shift_ff, shift_in;
   iswc_pkg::write_type write_ff, write_in;
   logic                overflow_ff, overflow_in;

   logic                full;
   logic                we;
   iswc_pkg::addr_type  waddr;
   iswc_pkg::value_type wdata;
   iswc_pkg::addr_type  raddr;

   assign full = count_ff >= iswc_pkg::count_type'(iswc_pkg::CAPACITY);

   // store write port: load, shift up, key placement
   always_comb begin
      we    = 1'b0;
      waddr = count_ff[iswc_pkg::ADDR_W-1:0];
      wdata = item_value;
      if (cmd.store_item && !full) begin
         we = 1'b1;
      end else if (cmd.shift_up) begin
         we    = 1'b1;
         waddr = slot_ff;
         wdata = rdata_ff;
      end else if (cmd.place_key) begin
         we    = 1'b1;
         waddr = slot_ff;
         wdata = key_ff;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         iswc_pkg::RD_I:          raddr = i_ff[iswc_pkg::ADDR_W-1:0];
         iswc_pkg::RD_I_PREV:     raddr = i_ff[iswc_pkg::ADDR_W-1:0] - iswc_pkg::addr_type'(1);
         iswc_pkg::RD_SLOT_PREV2: raddr = slot_ff - iswc_pkg::addr_type'(2);
         iswc_pkg::RD_K:          raddr = k_ff;
         iswc_pkg::RD_K_NEXT:     raddr = k_ff + iswc_pkg::addr_type'(1);
         default:                 raddr = k_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_ff <= store_ff[raddr];
      if (cmd.take_key) begin
         key_ff <= rdata_ff;
      end
      if (cmd.load_out) begin
         sorted_value_ff <= rdata_ff;
         last_out_ff     <= status.out_is_last;
      end
   end

   always_comb begin
      count_in    = count_ff;
      i_in        = i_ff;
      slot_in     = slot_ff;
      k_in        = k_ff;
      shift_in    = shift_ff;
      write_in    = write_ff;
      overflow_in = overflow_ff;
      if (cmd.store_item) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + iswc_pkg::count_type'(1);
         end
      end
      if (cmd.start_sort) begin
         i_in = iswc_pkg::count_type'(1);
         k_in = '0;
      end
      if (cmd.take_key) begin
         slot_in = i_ff[iswc_pkg::ADDR_W-1:0];
      end
      if (cmd.shift_up) begin
         slot_in  = slot_ff - iswc_pkg::addr_type'(1);
         shift_in = shift_ff + iswc_pkg::shift_type'(1);
         write_in = write_ff + iswc_pkg::write_type'(1);
      end
      if (cmd.place_key) begin
         write_in = write_ff + iswc_pkg::write_type'(1);
         i_in     = i_ff + iswc_pkg::count_type'(1);
      end
      if (cmd.next_out) begin
         k_in = k_ff + iswc_pkg::addr_type'(1);
      end
      if (cmd.clear_run) begin
         count_in    = '0;
         shift_in    = '0;
         write_in    = '0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         i_ff        <= '0;
         slot_ff     <= '0;
         k_ff        <= '0;
         shift_ff    <= '0;
         write_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         i_ff        <= i_in;
         slot_ff     <= slot_in;
         k_ff        <= k_in;
         shift_ff    <= shift_in;
         write_ff    <= write_in;
         overflow_ff <= overflow_in;
      end
   end

   assign status.sort_done   = i_ff >= count_ff;
   assign status.greater     = rdata_ff > key_ff;
   assign status.slot_is_one = slot_ff == iswc_pkg::addr_type'(1);
   assign status.out_is_last =
      (iswc_pkg::count_type'(k_ff) + iswc_pkg::count_type'(1)) == count_ff;

   assign sorted_value = sorted_value_ff;
   assign last_out     = last_out_ff;
   assign shift_count  = shift_ff;
   assign write_count  = write_ff;
   assign overflow     = overflow_ff;

endmodule

// File: rtl/iswc_controller.sv
// Controller: sequencing of load, insertion passes and response emission.
module iswc_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  iswc_pkg::status_type status,
   output iswc_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_LOAD,
      S_KEY_RD,
      S_KEY_LD,
      S_CMP,
      S_PLACE,
      S_OUT_LD,
      S_OUT_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == S_LOAD;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.rd_sel   = iswc_pkg::RD_K;
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.store_item = 1'b1;
               if (req_last) begin
                  cmd.start_sort = 1'b1;
                  state_in       = S_KEY_RD;
               end
            end
         end
         S_KEY_RD: begin
            if (status.sort_done) begin
               cmd.rd_sel = iswc_pkg::RD_K;
               state_in   = S_OUT_LD;
            end else begin
               cmd.rd_sel = iswc_pkg::RD_I;
               state_in   = S_KEY_LD;
            end
         end
         S_KEY_LD: begin
            cmd.take_key = 1'b1;
            cmd.rd_sel   = iswc_pkg::RD_I_PREV;
            state_in     = S_CMP;
         end
         S_CMP: begin
            if (status.greater) begin
               cmd.shift_up = 1'b1;
               cmd.rd_sel   = iswc_pkg::RD_SLOT_PREV2;
               if (status.slot_is_one) begin
                  state_in = S_PLACE;
               end
            end else begin
               cmd.place_key = 1'b1;
               state_in      = S_KEY_RD;
            end
         end
         S_PLACE: begin
            cmd.place_key = 1'b1;
            state_in      = S_KEY_RD;
         end
         S_OUT_LD: begin
            cmd.load_out = 1'b1;
            cmd.rd_sel   = iswc_pkg::RD_K_NEXT;
            rsp_valid_in = 1'b1;
            state_in     = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            cmd.rd_sel = iswc_pkg::RD_K_NEXT;
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (status.out_is_last) begin
                  cmd.clear_run = 1'b1;
                  state_in      = S_LOAD;
               end else begin
                  cmd.next_out = 1'b1;
                  state_in     = S_OUT_LD;
               end
            end
         end
         default: begin
            state_in     = S_LOAD;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/insertion_sort_with_counters_core.sv
// Top level: insertion sorter with shift and write counters.
//
//   Channel   Role   Handshake      Payload
//   req_chan  sink   valid/ready    value[31:0] signed, last_in
//   rsp_chan  source valid/ready    sorted_value[31:0] signed, last_out,
//                                   shift_count[10:0], write_count[11:0], overflow
//
// Load: one request per cycle while collecting; elements past the 64-entry
//   store are dropped and flag overflow on every response of the set.
// Sort: per key, S_KEY_RD and S_KEY_LD fetch it, then each compare in S_CMP moves
//   an element up or stops, and S_PLACE follows when the key lands in entry 0. The
//   store has a single write port and a single registered read port.
// Emit: each response is loaded in S_OUT_LD and held in S_OUT_WAIT until taken;
//   after the request marked last, none is taken until the final response goes.
// Reset: synchronous, active high; counters clear at once, the store is not
//   cleared since every entry whose read value is used was written in the set.
module insertion_sort_with_counters_core (
   input  logic         clock,
   input  logic         reset,
   iswc_req_if.sink     req_chan,
   iswc_rsp_if.source   rsp_chan
);

   iswc_pkg::cmd_type    cmd;
   iswc_pkg::status_type status;

   // sequencer: decides when a request is taken and when a response shows
   iswc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_in),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // store, indices, counters and the response register
   iswc_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .item_value   (req_chan.value),
      .status       (status),
      .sorted_value (rsp_chan.sorted_value),
      .last_out     (rsp_chan.last_out),
      .shift_count  (rsp_chan.shift_count),
      .write_count  (rsp_chan.write_count),
      .overflow     (rsp_chan.overflow)
   );

endmodule

// File: rtl/iswc_checker.sv
// Checker on the sorter's ports, bound to the top level.
`include "insertion_sort_with_counters_core_assert.svh"

module iswc_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input iswc_pkg::value_type sorted_value,
   input logic                last_out,
   input iswc_pkg::shift_type shift_count,
   input iswc_pkg::write_type write_count
);

   // a stalled response holds its payload
   `ISWC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(sorted_value) && $stable(last_out))

   // no request is taken while a response is pending
   `ISWC_ASSERT_IMP(a_no_req_during_rsp, clock, reset, rsp_valid, !req_ready)

   // more responses of the set follow: still closed to requests
   `ISWC_ASSERT_NXT(a_mid_run_closed, clock, reset, rsp_valid && rsp_ready && !last_out, !req_ready)

   // after the final response the block collects again
   `ISWC_ASSERT_NXT(a_reopen, clock, reset, rsp_valid && rsp_ready && last_out, req_ready)

   // every move is also a write
   `ISWC_ASSERT_IMP(a_count_order, clock, reset, rsp_valid, write_count >= {1'b0, shift_count})

endmodule

bind insertion_sort_with_counters_core iswc_checker u_iswc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .sorted_value (rsp_chan.sorted_value),
   .last_out     (rsp_chan.last_out),
   .shift_count  (rsp_chan.shift_count),
   .write_count  (rsp_chan.write_count)
);
